>>> design/bth_pkg.sv
// Shared types and constants of the boundary-tag heap allocator.
// No dependencies; imported by every module of the block.
package bth_pkg;

	localparam int HEAP_WORDS = 1024;
	localparam int AW         = $clog2(HEAP_WORDS);
	localparam int MIN_RESET  = 16;
	localparam int HOPW       = AW + 1;

	typedef logic [AW-1:0] addr_t;

	// One heap word: head uses all fields, foot uses tag and llink (uplink)
	typedef struct packed {
		logic  tag;
		addr_t size;
		addr_t llink;
		addr_t rlink;
	} word_t;

	// Per-field write enables
	typedef struct packed {
		logic tag;
		logic size;
		logic llink;
		logic rlink;
	} wen_t;

	// Controller states; each state is also the micro-operation issued to the datapath
	typedef enum logic [5:0] {
		ST_CLR, ST_IDLE,
		ST_A_READ, ST_A_EVAL, ST_A_DEC,
		ST_A_W_LR, ST_A_W_RL, ST_A_W_TP, ST_A_W_TF,
		ST_A_S_TF, ST_A_S_SZ, ST_A_S_NT, ST_A_S_NL, ST_A_S_QT, ST_A_S_QS,
		ST_F_CHK, ST_F_EV1, ST_F_EV2, ST_F_EV3,
		ST_F_A1, ST_F_A2, ST_F_A3, ST_F_A4, ST_F_A5, ST_F_A6,
		ST_F_A7, ST_F_A8, ST_F_A9, ST_F_A10, ST_F_A11,
		ST_F_B1, ST_F_B2, ST_F_B3, ST_F_B4, ST_F_B5, ST_F_B6,
		ST_F_B7, ST_F_B8, ST_F_B9,
		ST_F_C1, ST_F_C2, ST_F_C3, ST_F_C4, ST_F_C5,
		ST_F_D1, ST_F_D2, ST_F_D3, ST_F_D4, ST_F_D5, ST_F_D6,
		ST_OK, ST_FAIL
	} uop_t;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef struct packed {
		uop_t op;
		logic accept;
		logic respond;
	} cmd_t;

	typedef struct packed {
		logic  clr_last;
		kind_t kind;
		logic  empty;
		logic  found;
		logic  scan_end;
		logic  whole;
		logic  alone;
		logic  bad_addr;
		logic  bad_blk;
		logic  lo_used;
		logic  hi_used;
		logic  hi_alone;
		logic  out_busy;
	} stat_t;

endpackage

>>> design/bth_mem.sv
// Heap word store: four field arrays, one shared write address, one registered read.
// Depends on bth_pkg.
module bth_mem (
	input  logic           clk,
	input  bth_pkg::addr_t raddr,
	output bth_pkg::word_t rdata,
	input  bth_pkg::wen_t  we,
	input  bth_pkg::addr_t waddr,
	input  bth_pkg::word_t wdata
);
	import bth_pkg::*;

	logic  tag_m   [HEAP_WORDS];
	addr_t size_m  [HEAP_WORDS];
	addr_t llink_m [HEAP_WORDS];
	addr_t rlink_m [HEAP_WORDS];

	// field writes
	always_ff @(posedge clk) begin
		if (we.tag)   tag_m[waddr]   <= wdata.tag;
		if (we.size)  size_m[waddr]  <= wdata.size;
		if (we.llink) llink_m[waddr] <= wdata.llink;
		if (we.rlink) rlink_m[waddr] <= wdata.rlink;
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata.tag   <= tag_m[raddr];
		rdata.size  <= size_m[raddr];
		rdata.llink <= llink_m[raddr];
		rdata.rlink <= rlink_m[raddr];
	end

endmodule

>>> design/bth_dp.sv
// Datapath: heap store, pointer registers, rover, result beat register.
// Depends on bth_pkg and bth_mem; driven by bth_ctrl through cmd_t.
module bth_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  bth_pkg::cmd_t  cmd,
	output bth_pkg::stat_t st,
	input  logic           cfg_we,
	input  logic [9:0]     cfg_wdata,
	input  logic           in_kind,
	input  logic [9:0]     in_req,
	input  logic [9:0]     in_addr,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [9:0]     out_addr,
	output logic           out_success
);
	import bth_pkg::*;

	word_t rd;
	addr_t raddr, waddr;
	wen_t  we;
	word_t wdata;

	kind_t           kind_q;
	addr_t           n_q, p_q, start_q, sz_q, llp_q, rlp_q, res_q;
	addr_t           s_q, hi_q, q_q, q1_q, tsz_q;
	logic            lo_used_q;
	logic [HOPW-1:0] hops_q;
	addr_t           rover_q, min_q, clr_q;
	logic            empty_q, ov_q, osucc_q;
	addr_t           oaddr_q;

	addr_t f, rest, nf, qs, tf;

	bth_mem u_mem (
		.clk   (clk),
		.raddr (raddr),
		.rdata (rd),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata)
	);

	// derived addresses, all wrapping modulo the heap size
	assign f    = p_q + sz_q - addr_t'(1);
	assign rest = sz_q - n_q;
	assign nf   = p_q + rest - addr_t'(1);
	assign qs   = p_q + rest;
	assign tf   = hi_q + tsz_q - addr_t'(1);

	// status
	always_comb begin
		st.clr_last = (clr_q == addr_t'(HEAP_WORDS - 1));
		st.kind     = kind_q;
		st.empty    = empty_q;
		st.found    = (rd.size >= n_q);
		st.scan_end = (rd.rlink == start_q) || (hops_q == HOPW'(HEAP_WORDS - 1));
		st.whole    = (rest <= min_q) || (rest < addr_t'(2));
		st.alone    = (rlp_q == p_q);
		st.bad_addr = (p_q == '0) || (p_q >= addr_t'(HEAP_WORDS - 1));
		st.bad_blk  = !rd.tag || (rd.size == '0) ||
			({1'b0, rd.size} > (HOPW'(HEAP_WORDS - 1) - {1'b0, p_q}));
		st.lo_used  = lo_used_q;
		st.hi_used  = rd.tag;
		st.hi_alone = (q1_q == hi_q);
		st.out_busy = ov_q && !out_ready;
	end

	// read address
	always_comb begin
		case (cmd.op)
			ST_F_EV1:        raddr = p_q - addr_t'(1);
			ST_F_EV2:        raddr = p_q + sz_q;
			ST_F_A6:         raddr = rover_q;
			ST_F_C4, ST_F_D1: raddr = s_q;
			default:         raddr = p_q;
		endcase
	end

	// write port: one field per step, all fields during the clearing pass
	always_comb begin
		we    = '0;
		waddr = p_q;
		wdata = '0;
		case (cmd.op)
			ST_CLR: begin
				we    = '1;
				waddr = clr_q;
				wdata.tag   = (clr_q == '0) || (clr_q == addr_t'(HEAP_WORDS - 1));
				wdata.size  = (clr_q == addr_t'(1)) ? addr_t'(HEAP_WORDS - 2) : '0;
				wdata.llink = ((clr_q == addr_t'(1)) || (clr_q == addr_t'(HEAP_WORDS - 2)))
					? addr_t'(1) : '0;
				wdata.rlink = (clr_q == addr_t'(1)) ? addr_t'(1) : '0;
			end
			ST_A_W_LR: begin we.llink = 1'b1; waddr = rover_q; wdata.llink = llp_q; end
			ST_A_W_RL: begin we.rlink = 1'b1; waddr = llp_q; wdata.rlink = rover_q; end
			ST_A_W_TP: begin we.tag = 1'b1; wdata.tag = 1'b1; end
			ST_A_W_TF, ST_A_S_TF: begin we.tag = 1'b1; waddr = f; wdata.tag = 1'b1; end
			ST_A_S_SZ: begin we.size = 1'b1; wdata.size = rest; end
			ST_A_S_NT: begin we.tag = 1'b1; waddr = nf; end
			ST_A_S_NL: begin we.llink = 1'b1; waddr = nf; wdata.llink = p_q; end
			ST_A_S_QT: begin we.tag = 1'b1; waddr = qs; wdata.tag = 1'b1; end
			ST_A_S_QS: begin we.size = 1'b1; waddr = qs; wdata.size = n_q; end
			ST_F_A1, ST_F_B1, ST_F_C3, ST_F_D6: begin we.tag = 1'b1; end
			ST_F_A2: begin we.llink = 1'b1; waddr = f; wdata.llink = p_q; end
			ST_F_A3, ST_F_C2: begin we.tag = 1'b1; waddr = f; end
			ST_F_A4, ST_F_B2: begin we.llink = 1'b1; wdata.llink = p_q; end
			ST_F_A5, ST_F_B3: begin we.rlink = 1'b1; wdata.rlink = p_q; end
			ST_F_A8: begin we.rlink = 1'b1; wdata.rlink = rover_q; end
			ST_F_A9, ST_F_B4: begin we.llink = 1'b1; wdata.llink = q_q; end
			ST_F_A10, ST_F_B5: begin we.rlink = 1'b1; waddr = q_q; wdata.rlink = p_q; end
			ST_F_A11: begin we.llink = 1'b1; waddr = rover_q; wdata.llink = p_q; end
			ST_F_B6: begin we.rlink = 1'b1; wdata.rlink = q1_q; end
			ST_F_B7: begin we.llink = 1'b1; waddr = q1_q; wdata.llink = p_q; end
			ST_F_B8: begin we.size = 1'b1; wdata.size = sz_q + tsz_q; end
			ST_F_B9: begin we.llink = 1'b1; waddr = tf; wdata.llink = p_q; end
			ST_F_C1: begin we.llink = 1'b1; waddr = f; wdata.llink = s_q; end
			ST_F_C5: begin we.size = 1'b1; waddr = s_q; wdata.size = rd.size + sz_q; end
			ST_F_D2: begin
				we.size = 1'b1; waddr = s_q; wdata.size = rd.size + sz_q + tsz_q;
			end
			ST_F_D3: begin we.rlink = 1'b1; waddr = q_q; wdata.rlink = q1_q; end
			ST_F_D4: begin we.llink = 1'b1; waddr = q1_q; wdata.llink = q_q; end
			ST_F_D5: begin we.llink = 1'b1; waddr = tf; wdata.llink = s_q; end
			default: ;
		endcase
	end

	// item registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q  <= kind_t'(in_kind);
			n_q     <= (in_req < 10'd2) ? addr_t'(2) : addr_t'(in_req);
			p_q     <= in_kind ? addr_t'(in_addr) : rover_q;
			start_q <= rover_q;
			hops_q  <= '0;
			res_q   <= '0;
		end
		case (cmd.op)
			ST_A_EVAL: begin
				if (rd.size >= n_q) begin
					sz_q  <= rd.size;
					llp_q <= rd.llink;
					rlp_q <= rd.rlink;
				end else begin
					p_q    <= rd.rlink;
					hops_q <= hops_q + HOPW'(1);
				end
			end
			ST_A_DEC: res_q <= st.whole ? p_q : qs;
			ST_F_EV1: sz_q <= rd.size;
			ST_F_EV2: begin
				lo_used_q <= rd.tag;
				s_q       <= rd.llink;
				hi_q      <= p_q + sz_q;
			end
			ST_F_EV3: begin
				q_q   <= rd.llink;
				q1_q  <= rd.rlink;
				tsz_q <= rd.size;
			end
			ST_F_A7: q_q <= rd.llink;
			default: ;
		endcase
	end

	// rover, list state, clearing counter and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rover_q <= addr_t'(1);
			empty_q <= 1'b0;
			min_q   <= addr_t'(MIN_RESET);
			clr_q   <= '0;
		end else begin
			if (cfg_we)
				min_q <= cfg_wdata;
			case (cmd.op)
				ST_CLR:    clr_q <= clr_q + addr_t'(1);
				ST_A_EVAL: if (rd.size >= n_q) rover_q <= rd.rlink;
				ST_A_DEC:  if (st.whole && st.alone) empty_q <= 1'b1;
				ST_F_A5: begin
					empty_q <= 1'b0;
					rover_q <= p_q;
				end
				ST_F_A11:  rover_q <= p_q;
				ST_F_B9:   if (rover_q == hi_q) rover_q <= p_q;
				ST_F_D6:   if (rover_q == hi_q) rover_q <= s_q;
				default: ;
			endcase
		end
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (cmd.respond)
			ov_q <= 1'b1;
		else if (out_ready)
			ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			oaddr_q <= (cmd.op == ST_OK) ? res_q : '0;
			osucc_q <= (cmd.op == ST_OK);
		end
	end

	assign out_valid   = ov_q;
	assign out_addr    = oaddr_q;
	assign out_success = osucc_q;

endmodule

>>> design/bth_ctrl.sv
// Controller: sequences list scans, splits and merges as datapath micro-operations.
// Depends on bth_pkg.
module bth_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           in_kind,
	input  bth_pkg::stat_t st,
	output bth_pkg::cmd_t  cmd
);
	import bth_pkg::*;

	uop_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLR;
		else
			state_q <= state_d;
	end

	// next state and command
	always_comb begin
		state_d     = state_q;
		in_ready    = (state_q == ST_IDLE);
		cmd.op      = state_q;
		cmd.accept  = (state_q == ST_IDLE) && in_valid;
		cmd.respond = ((state_q == ST_OK) || (state_q == ST_FAIL)) && !st.out_busy;
		case (state_q)
			ST_CLR:    if (st.clr_last) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = (in_kind == KIND_FREE) ? ST_F_CHK : ST_A_READ;
			// first-fit scan
			ST_A_READ: state_d = st.empty ? ST_FAIL : ST_A_EVAL;
			ST_A_EVAL: begin
				if (st.found)
					state_d = ST_A_DEC;
				else if (st.scan_end)
					state_d = ST_FAIL;
				else
					state_d = ST_A_READ;
			end
			ST_A_DEC: begin
				if (!st.whole)
					state_d = ST_A_S_TF;
				else if (st.alone)
					state_d = ST_A_W_TP;
				else
					state_d = ST_A_W_LR;
			end
			ST_A_W_LR: state_d = ST_A_W_RL;
			ST_A_W_RL: state_d = ST_A_W_TP;
			ST_A_W_TP: state_d = ST_A_W_TF;
			ST_A_W_TF: state_d = ST_OK;
			ST_A_S_TF: state_d = ST_A_S_SZ;
			ST_A_S_SZ: state_d = ST_A_S_NT;
			ST_A_S_NT: state_d = ST_A_S_NL;
			ST_A_S_NL: state_d = ST_A_S_QT;
			ST_A_S_QT: state_d = ST_A_S_QS;
			ST_A_S_QS: state_d = ST_OK;
			// free: checks and neighbour reads
			ST_F_CHK:  state_d = st.bad_addr ? ST_FAIL : ST_F_EV1;
			ST_F_EV1:  state_d = st.bad_blk ? ST_FAIL : ST_F_EV2;
			ST_F_EV2:  state_d = ST_F_EV3;
			ST_F_EV3: begin
				if (st.lo_used)
					state_d = st.hi_used ? ST_F_A1 : ST_F_B1;
				else
					state_d = st.hi_used ? ST_F_C1 : ST_F_D1;
			end
			// both neighbours used: insert before rover
			ST_F_A1:   state_d = ST_F_A2;
			ST_F_A2:   state_d = ST_F_A3;
			ST_F_A3:   state_d = st.empty ? ST_F_A4 : ST_F_A6;
			ST_F_A4:   state_d = ST_F_A5;
			ST_F_A5:   state_d = ST_OK;
			ST_F_A6:   state_d = ST_F_A7;
			ST_F_A7:   state_d = ST_F_A8;
			ST_F_A8:   state_d = ST_F_A9;
			ST_F_A9:   state_d = ST_F_A10;
			ST_F_A10:  state_d = ST_F_A11;
			ST_F_A11:  state_d = ST_OK;
			// upper neighbour free: take over its list place
			ST_F_B1:   state_d = st.hi_alone ? ST_F_B2 : ST_F_B4;
			ST_F_B2:   state_d = ST_F_B3;
			ST_F_B3:   state_d = ST_F_B8;
			ST_F_B4:   state_d = ST_F_B5;
			ST_F_B5:   state_d = ST_F_B6;
			ST_F_B6:   state_d = ST_F_B7;
			ST_F_B7:   state_d = ST_F_B8;
			ST_F_B8:   state_d = ST_F_B9;
			ST_F_B9:   state_d = ST_OK;
			// lower neighbour free: grow it
			ST_F_C1:   state_d = ST_F_C2;
			ST_F_C2:   state_d = ST_F_C3;
			ST_F_C3:   state_d = ST_F_C4;
			ST_F_C4:   state_d = ST_F_C5;
			ST_F_C5:   state_d = ST_OK;
			// both free: grow lower, unlink upper
			ST_F_D1:   state_d = ST_F_D2;
			ST_F_D2:   state_d = ST_F_D3;
			ST_F_D3:   state_d = ST_F_D4;
			ST_F_D4:   state_d = ST_F_D5;
			ST_F_D5:   state_d = ST_F_D6;
			ST_F_D6:   state_d = ST_OK;
			ST_OK, ST_FAIL: if (!st.out_busy) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

endmodule

>>> design/boundary_tag_heap_allocator.sv
// Boundary-tag heap allocator over a 1024-word heap with a circular first-fit
// free list and a roving start. After reset a clearing pass builds the initial
// heap; no beat is accepted until it ends (min_leftover may be written).
// One item is handled at a time over the single heap memory port; an allocate
// visits the free blocks one by one, so the list length sets the allocate time.
// The result beat sits in an output register.
// Depends on bth_pkg, bth_ctrl, bth_dp, bth_mem.
module boundary_tag_heap_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [9:0] request_words, [19:10] block_addr, rest 0
	input  logic        s_axis_tuser,   // [0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [9:0] result_addr, rest 0
	output logic        m_axis_tuser    // [0] success
);
	import bth_pkg::*;

	cmd_t       cmd;
	stat_t      st;
	logic [9:0] res_addr;

	bth_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_kind  (s_axis_tuser),
		.st       (st),
		.cmd      (cmd)
	);

	bth_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_kind     (s_axis_tuser),
		.in_req      (s_axis_tdata[9:0]),
		.in_addr     (s_axis_tdata[19:10]),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_addr    (res_addr),
		.out_success (m_axis_tuser)
	);

	assign m_axis_tdata = {6'd0, res_addr};

endmodule

>>> sim/boundary_tag_heap_allocator_test.sv
// Self-checking testbench for the boundary-tag heap allocator.
// Drives allocate and free beats, predicts each result from a behavioural heap
// model kept here, and compares; depends on bth_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module boundary_tag_heap_allocator_test;
	import bth_pkg::*;

	localparam int N = HEAP_WORDS;

	typedef struct {
		addr_t addr;
		logic  ok;
	} heap_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [9:0]  cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // [9:0] request_words, [19:10] block_addr
	logic        s_axis_tuser = 1'b0; // [0] kind
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;        // [9:0] result_addr
	logic        m_axis_tuser;        // [0] success

	boundary_tag_heap_allocator uut (.*);

	always #5 clk = ~clk;

	// Shadow heap
	logic  sh_tag [N];
	addr_t sh_size[N];
	addr_t sh_ll  [N];
	addr_t sh_rl  [N];
	addr_t sh_rover;
	logic  sh_empty;
	int    sh_min;

	heap_reply_t reply_q[$];
	int          live_blocks[$];
	int          freed_blocks[$];
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          hold_left = 0;
	bit          hold_arm = 0;
	int          n_beats = 0;
	int          n_replies = 0;
	int          n_allocs_ok = 0;
	int          n_frees_ok = 0;
	int          n_errors = 0;

	function automatic int foot_addr(int p);
		return (p + sh_size[p] + N - 1) % N;
	endfunction

	function automatic void heap_reset();
		for (int i = 0; i < N; i++) begin
			sh_tag[i] = 0; sh_size[i] = '0; sh_ll[i] = '0; sh_rl[i] = '0;
		end
		sh_tag[0] = 1;
		sh_tag[N-1] = 1;
		sh_size[1] = addr_t'(N - 2);
		sh_ll[1] = 1;
		sh_rl[1] = 1;
		sh_ll[N-2] = 1;
		sh_rover = 1;
		sh_empty = 0;
		sh_min = MIN_RESET;
	endfunction

	function automatic heap_reply_t heap_alloc(int req);
		heap_reply_t r;
		int n, p, start, f, rest, q, l, nf;
		bit found;
		r.addr = '0; r.ok = 0;
		n = (req < 2) ? 2 : req;
		if (sh_empty) return r;
		start = sh_rover;
		p = start;
		found = 0;
		for (int h = 0; h < N; h++) begin
			if (int'(sh_size[p]) >= n) begin found = 1; break; end
			p = sh_rl[p];
			if (p == start) break;
		end
		if (!found) return r;
		f = foot_addr(p);
		sh_rover = sh_rl[p];
		rest = int'(sh_size[p]) - n;
		if (rest <= sh_min || rest < 2) begin
			// whole block handed out
			if (int'(sh_rover) == p) sh_empty = 1;
			else begin
				l = sh_ll[p];
				sh_ll[sh_rover] = addr_t'(l);
				sh_rl[l] = sh_rover;
			end
			sh_tag[p] = 1; sh_tag[f] = 1;
			q = p;
		end else begin
			// split: top part goes out
			sh_tag[f] = 1;
			sh_size[p] = addr_t'(rest);
			nf = foot_addr(p);
			sh_tag[nf] = 0; sh_ll[nf] = addr_t'(p);
			q = (nf + 1) % N;
			sh_tag[q] = 1; sh_size[q] = addr_t'(n);
		end
		r.addr = addr_t'(q); r.ok = 1;
		return r;
	endfunction

	function automatic bit free_ignored(int p);
		return p == 0 || p >= N - 1 || sh_tag[p] == 0 || sh_size[p] == 0 ||
			int'(sh_size[p]) > N - 1 - p;
	endfunction

	function automatic heap_reply_t heap_free(int p);
		heap_reply_t r;
		int sz, lo, hi, f, t, q, q1, s, tf, rv;
		r.addr = '0; r.ok = 0;
		if (free_ignored(p)) return r;
		sz = sh_size[p];
		lo = p - 1; hi = p + sz; f = p + sz - 1;
		if (sh_tag[lo]) begin
			if (sh_tag[hi]) begin
				// both neighbours used: insert before rover
				sh_tag[p] = 0; sh_ll[f] = addr_t'(p); sh_tag[f] = 0;
				if (sh_empty) begin
					sh_ll[p] = addr_t'(p); sh_rl[p] = addr_t'(p); sh_empty = 0;
				end else begin
					rv = sh_rover; q = sh_ll[rv];
					sh_rl[p] = addr_t'(rv); sh_ll[p] = addr_t'(q);
					sh_rl[q] = addr_t'(p); sh_ll[rv] = addr_t'(p);
				end
				sh_rover = addr_t'(p);
			end else begin
				// upper neighbour free: take its place in the list
				t = hi; q = sh_ll[t]; q1 = sh_rl[t];
				sh_tag[p] = 0;
				if (q1 == t) begin
					sh_ll[p] = addr_t'(p); sh_rl[p] = addr_t'(p);
				end else begin
					sh_ll[p] = addr_t'(q); sh_rl[q] = addr_t'(p);
					sh_rl[p] = addr_t'(q1); sh_ll[q1] = addr_t'(p);
				end
				sh_size[p] = addr_t'(sz + sh_size[t]);
				sh_ll[foot_addr(t)] = addr_t'(p);
				if (int'(sh_rover) == t) sh_rover = addr_t'(p);
			end
		end else begin
			s = sh_ll[lo];
			if (sh_tag[hi]) begin
				// lower neighbour free: grow it
				sh_ll[f] = addr_t'(s); sh_tag[f] = 0; sh_tag[p] = 0;
				sh_size[s] = addr_t'(sh_size[s] + sz);
			end else begin
				// both free: lower absorbs both, upper leaves the list
				t = hi; q = sh_ll[t]; q1 = sh_rl[t]; tf = foot_addr(t);
				sh_size[s] = addr_t'(sh_size[s] + sz + sh_size[t]);
				sh_rl[q] = addr_t'(q1); sh_ll[q1] = addr_t'(q);
				sh_ll[tf] = addr_t'(s);
				sh_tag[p] = 0;
				if (int'(sh_rover) == t) sh_rover = addr_t'(s);
			end
		end
		r.ok = 1;
		return r;
	endfunction

	// Send one request beat; the expected reply is queued on acceptance
	task automatic send_request(input kind_t k, input int req, input int addr,
			output heap_reply_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= k;
		s_axis_tdata  <= {4'b0, addr[9:0], req[9:0]};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		r = (k == KIND_ALLOC) ? heap_alloc(req) : heap_free(addr);
		reply_q.push_back(r);
		n_beats++;
		if (r.ok && k == KIND_ALLOC) live_blocks.push_back(int'(r.addr));
		if (r.ok && k == KIND_FREE) freed_blocks.push_back(addr);
	endtask

	task automatic alloc_words(input int req, output int a);
		heap_reply_t r;
		send_request(KIND_ALLOC, req, $urandom_range(N - 1), r);
		a = r.addr;
	endtask

	task automatic free_block(input int a);
		heap_reply_t r;
		foreach (live_blocks[i])
			if (live_blocks[i] == a) begin live_blocks.delete(i); break; end
		send_request(KIND_FREE, $urandom_range(1, 1022), a, r);
	endtask

	task automatic wait_replies();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (reply_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_min_leftover(input int v);
		cfg_we <= 1'b1;
		cfg_wdata <= v[9:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		sh_min = v;
	endtask

	// Result checking and receiver stalls
	always @(posedge clk) begin
		heap_reply_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			n_replies++;
			if (reply_q.size() == 0) begin
				$error("result beat with nothing expected: addr %0d success %0d",
					m_axis_tdata[9:0], m_axis_tuser);
				n_errors++;
			end else begin
				e = reply_q.pop_front();
				if (m_axis_tdata[9:0] !== e.addr) begin
					$error("result_addr expected %0d actual %0d", e.addr, m_axis_tdata[9:0]);
					n_errors++;
				end
				if (m_axis_tuser !== e.ok) begin
					$error("success expected %0d actual %0d", e.ok, m_axis_tuser);
					n_errors++;
				end
			end
		end
		m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
	end

	// Long receiver hold-off, counted in cycles
	always @(posedge clk) begin
		if (hold_arm) begin
			hold_arm = 0;
			hold_left <= 400;
		end else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	task automatic test_directed();
		int a, b, c, d, e;
		heap_reply_t r;
		alloc_words(1, a);
		alloc_words(2, b);
		alloc_words(30, c);
		alloc_words(30, d);
		alloc_words(1022, e);                  // no block that large
		send_request(KIND_FREE, 5, 0, r);      // address zero
		send_request(KIND_FREE, 5, 1023, r);   // end sentinel
		send_request(KIND_FREE, 5, 1, r);      // head of a free block
		free_block(b);                         // neighbours used
		free_block(d);
		free_block(c);                         // both neighbours free
		send_request(KIND_FREE, 5, c, r);      // second free of a merged head
		free_block(a);
		alloc_words(1010, a);                  // small leftover: whole block, list empty
		alloc_words(5, b);                     // empty list
		free_block(a);                         // insert into empty list
		alloc_words(1022, a);                  // exact fit
		free_block(a);
		alloc_words(1, a);
		alloc_words(1, b);
		free_block(a);                         // neighbours used
		free_block(b);
		wait_replies();
	endtask

	task automatic random_item();
		int r, p, a;
		heap_reply_t rep;
		r = $urandom_range(99);
		if (r < 8) begin
			// ignored frees: bad addresses, stale heads, double frees
			case ($urandom_range(3))
				0: p = $urandom_range(1) ? 0 : N - 1;
				1: p = (freed_blocks.size() != 0) ?
					freed_blocks[$urandom_range(freed_blocks.size() - 1)] : 0;
				default: p = $urandom_range(N - 1);
			endcase
			if (!free_ignored(p)) p = 0;
			send_request(KIND_FREE, $urandom_range(1, 1022), p, rep);
		end else if (live_blocks.size() != 0 && (r < 52 || live_blocks.size() > 40)) begin
			free_block(live_blocks[$urandom_range(live_blocks.size() - 1)]);
		end else begin
			r = $urandom_range(99);
			if (r < 80) a = $urandom_range(1, 40);
			else if (r < 96) a = $urandom_range(41, 400);
			else a = $urandom_range(401, 1022);
			alloc_words(a, p);
		end
	endtask

	task automatic test_random(input int count, input int idle, input int stall, input int minv);
		send_idle_pct = idle;
		stall_pct = stall;
		set_min_leftover(minv);
		repeat (count) random_item();
		wait_replies();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_arm = 1;
		repeat (30) random_item();
		wait_replies();
	endtask

	task automatic test_pause_until_empty();
		send_idle_pct = 0;
		stall_pct = 50;
		repeat (20) begin
			random_item();
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while (reply_q.size() != 0) @(posedge clk);
		end
		wait_replies();
	endtask

	initial begin
		heap_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_min_leftover(MIN_RESET);
		test_directed();
		test_random(350, 0, 0, 0);
		test_random(350, 88, 0, 1023);
		test_backpressure();
		test_random(350, 0, 88, 16);
		test_random(300, 12, 12, $urandom_range(1, 1022));
		test_pause_until_empty();
		$display("covered %0d request beats, %0d replies (%0d allocations, %0d frees)",
			n_beats, n_replies, n_allocs_ok, n_frees_ok);
		$display("min_leftover swept over 0, 1023, 16 and a random value, four idle mixes");
		if (n_errors == 0 && reply_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Count accepted request beats by kind for the summary
	always @(posedge clk)
		if (s_axis_tvalid && s_axis_tready)
			if (s_axis_tuser == KIND_ALLOC) n_allocs_ok++;
			else n_frees_ok++;

	initial begin
		#40ms;
		$display("FAIL");
		$finish;
	end

endmodule
